### hdl/prt_pkg.sv
// ============================================================================
// prt_pkg: shared types and constants of the prescaled reference timer
// Item structs, item kind codes, register offsets and mode/event bit fields.
// ============================================================================
`default_nettype none

package prt_pkg;

  // Default slow clock multiplier applied in clock mode 2
  localparam int unsigned SLOW_CLOCK_FACTOR_DEF = 16;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register byte offsets
  localparam logic [4:0] OFF_MODE = 5'h00;
  localparam logic [4:0] OFF_REF  = 5'h04;
  localparam logic [4:0] OFF_CAP  = 5'h08;
  localparam logic [4:0] OFF_CNT  = 5'h0c;
  localparam logic [4:0] OFF_EVT  = 5'h11;

  // Mode word bit positions
  localparam int unsigned MODE_EN_BIT      = 0;
  localparam int unsigned MODE_CLK_LSB     = 1;
  localparam int unsigned MODE_RESTART_BIT = 3;
  localparam int unsigned MODE_IEN_BIT     = 4;
  localparam int unsigned MODE_PRE_LSB     = 8;

  // Clock mode codes
  localparam logic [1:0] CLK_SYS  = 2'd1;
  localparam logic [1:0] CLK_SLOW = 2'd2;

  // Event flag bit of the reference event
  localparam int unsigned EVT_REF_BIT = 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  addr;
    logic [15:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        irq_out;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/prt_prescaler.sv
// ============================================================================
// prt_prescaler: tick divider of the timer
// Counts tick items while the timer runs and strobes one divided tick each
// time the divisor, (prescale+1) or (prescale+1)*SLOW_CLOCK_FACTOR, is reached.
// ============================================================================
`default_nettype none

module prt_prescaler #(
  parameter int unsigned SLOW_CLOCK_FACTOR = prt_pkg::SLOW_CLOCK_FACTOR_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire prt_pkg::in_item_t item,
  input  wire logic [15:0]      mode_word,
  output logic                  div_tick
);
  import prt_pkg::*;

  // Phase holds up to 256*factor-1; one more bit for the incremented value
  localparam int unsigned PW = $clog2(256 * SLOW_CLOCK_FACTOR);

  logic [PW-1:0] phase_r, phase_nxt;
  logic [PW:0]   phase_inc;
  logic [PW:0]   divisor;
  logic [PW:0]   base;
  logic [PW:0]   factor;
  logic [1:0]    clk_mode;
  logic          running;
  logic          tick_run;
  logic          restart;

  assign clk_mode = mode_word[MODE_CLK_LSB +: 2];

  assign running = mode_word[MODE_EN_BIT] && mode_word[MODE_RESTART_BIT] &&
                   (clk_mode == CLK_SYS || clk_mode == CLK_SLOW);

  // Divisor: prescale+1, times the slow factor in clock mode 2
  assign base    = (PW+1)'(mode_word[MODE_PRE_LSB +: 8]) + (PW+1)'(1);
  assign factor  = (clk_mode == CLK_SLOW) ? (PW+1)'(SLOW_CLOCK_FACTOR) : (PW+1)'(1);
  assign divisor = (PW+1)'(base * factor);

  assign phase_inc = {1'b0, phase_r} + (PW+1)'(1);
  assign tick_run  = step && (item.mode == KIND_TICK) && running;
  assign div_tick  = tick_run && (phase_inc >= divisor);

  // Mode or reference writes restart the divided period
  assign restart = step && (item.mode == KIND_WRITE) &&
                   (item.addr == OFF_MODE || item.addr == OFF_REF);

  always_comb begin
    phase_nxt = phase_r;
    if (restart) begin
      phase_nxt = '0;
    end else if (tick_run) begin
      phase_nxt = div_tick ? '0 : phase_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/prt_regs.sv
// ============================================================================
// prt_regs: register file and down counter of the timer
// Applies bus reads and writes and divided ticks, and forms the result item.
// ============================================================================
`default_nettype none

module prt_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire prt_pkg::in_item_t item,
  input  wire logic              div_tick,
  output logic [15:0]            mode_word,
  output prt_pkg::out_item_t     result
);
  import prt_pkg::*;

  logic [15:0] mode_r, mode_nxt;
  logic [15:0] ref_r, ref_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [15:0] evt_r, evt_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] rd_val;
  logic        do_read;
  logic        do_write;

  assign mode_word = mode_r;
  assign do_read   = step && (item.mode == KIND_READ);
  assign do_write  = step && (item.mode == KIND_WRITE);

  // Read mux
  always_comb begin
    case (item.addr)
      OFF_MODE: rd_val = mode_r;
      OFF_REF:  rd_val = ref_r;
      OFF_CAP:  rd_val = cap_r;
      OFF_CNT:  rd_val = ref_r - cnt_r;
      OFF_EVT:  rd_val = evt_r;
      default:  rd_val = '0;
    endcase
  end

  // Next state: divided tick or bus write (never both in one item)
  always_comb begin
    mode_nxt = mode_r;
    ref_nxt  = ref_r;
    cap_nxt  = cap_r;
    evt_nxt  = evt_r;
    cnt_nxt  = cnt_r;
    if (div_tick) begin
      if (cnt_r <= 16'd1) begin
        evt_nxt[EVT_REF_BIT] = 1'b1;
        cnt_nxt = ref_r;
      end else begin
        cnt_nxt = cnt_r - 16'd1;
      end
    end else if (do_write) begin
      case (item.addr)
        OFF_MODE: begin
          // dropping the enable zeroes the reference
          if (mode_r[MODE_EN_BIT] && !item.wdata[MODE_EN_BIT]) begin
            ref_nxt = '0;
          end
          mode_nxt = item.wdata;
        end
        OFF_REF: ref_nxt = item.wdata;
        OFF_CAP: cap_nxt = item.wdata;
        OFF_CNT: cnt_nxt = item.wdata;
        OFF_EVT: evt_nxt = evt_r & ~item.wdata;
        default: ;
      endcase
    end
  end

  // Result item of the current step
  always_comb begin
    result.rdata   = do_read ? rd_val : 16'd0;
    result.irq_out = mode_nxt[MODE_IEN_BIT] && evt_nxt[EVT_REF_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      ref_r  <= '0;
      cap_r  <= '0;
      evt_r  <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      ref_r  <= ref_nxt;
      cap_r  <= cap_nxt;
      evt_r  <= evt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/prescaled_reference_timer_core.sv
// ============================================================================
// prescaled_reference_timer_core: register-mapped timer with prescaler
// Top level: input register, timer logic, result register.
// ============================================================================
// Each item (tick, bus read or bus write) is taken into an input register,
// applied to the timer registers once the result register is free or
// draining, and its result (read data and interrupt level) lands in an
// output register. One item is accepted every clock cycle while the result
// is not stalled; the path runs through the input register, the register
// update and the result register. A stalled result only holds the input
// side back once the input register is also full.
`default_nettype none

module prescaled_reference_timer_core #(
  parameter int unsigned SLOW_CLOCK_FACTOR = prt_pkg::SLOW_CLOCK_FACTOR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire prt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output prt_pkg::out_item_t      out_data
);
  import prt_pkg::*;

  in_item_t  item_r;
  logic      item_vld_r, item_vld_nxt;
  out_item_t out_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t result;
  logic [15:0] mode_word;
  logic      adv;
  logic      div_tick;

  // Handshake: advance when the result register is free or draining
  assign adv          = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall     = item_vld_r && !adv;
  assign item_vld_nxt = (in_valid && !in_stall) || (item_vld_r && !adv);
  assign out_vld_nxt  = adv || (out_vld_r && out_stall);
  assign out_valid    = out_vld_r;
  assign out_data     = out_r;

  prt_prescaler #(
    .SLOW_CLOCK_FACTOR(SLOW_CLOCK_FACTOR)
  ) u_prescaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (item_r),
    .mode_word(mode_word),
    .div_tick (div_tick)
  );

  prt_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (item_r),
    .div_tick (div_tick),
    .mode_word(mode_word),
    .result   (result)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

endmodule

`default_nettype wire
